>>> hw/rtl/direction_to_incl_azimuth_core_macros.svh
// Assertion macros shared by the direction-to-angles pipeline.
`ifndef DIRECTION_TO_INCL_AZIMUTH_CORE_MACROS_SVH
`define DIRECTION_TO_INCL_AZIMUTH_CORE_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define DIA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define DIA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

>>> hw/rtl/dia_pkg.sv
// Package with constants, types and the arctangent table of the direction pipeline.
`timescale 1ns / 1ps
`default_nettype none
package dia_pkg;
  localparam int COMPONENT_BITS_DEF  = 16;
  localparam int ANGLE_FRAC_BITS_DEF = 8;
  localparam int CORDIC_STAGES_DEF   = 16;
  localparam int CFG_W   = 12;
  localparam int INCL_W  = 16;
  localparam int AZI_W   = 17;
  localparam int IDX_W   = 1;
  localparam int VW      = 34;   // signed CORDIC datapath width
  localparam int AW      = 34;   // signed angle width, 2^-24 degree
  localparam int INT_FRAC = 24;

  typedef enum logic [IDX_W-1:0] {
    REG_NEAR_ZERO_ANGLE = 1'b0,
    REG_NEAR_ZERO_COMP  = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [CFG_W-1:0] near_zero_angle;
    logic [CFG_W-1:0] near_zero_component;
  } cfg_t;

  function automatic logic signed [AW-1:0] atan_val(input int i);
    logic signed [AW-1:0] t [32];
    t = '{34'sd754974720, 34'sd445687602, 34'sd235489088, 34'sd119537938,
          34'sd60000934, 34'sd30029717, 34'sd15018523, 34'sd7509720,
          34'sd3754917, 34'sd1877466, 34'sd938734, 34'sd469367, 34'sd234684,
          34'sd117342, 34'sd58671, 34'sd29335, 34'sd14668, 34'sd7334,
          34'sd3667, 34'sd1833, 34'sd917, 34'sd458, 34'sd229, 34'sd115,
          34'sd57, 34'sd29, 34'sd14, 34'sd7, 34'sd4, 34'sd2, 34'sd1, 34'sd0};
    return t[i];
  endfunction
endpackage
`default_nettype wire

>>> hw/rtl/dia_if.sv
// Valid/ready channel interface with a generic payload.
`timescale 1ns / 1ps
`default_nettype none
interface dia_if #(parameter int W = 1);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/dia_isqrt_stage.sv
// One registered stage of two restoring square roots, two result bits per stage.
`timescale 1ns / 1ps
`default_nettype none
module dia_isqrt_stage
  import dia_pkg::*;
#(
  parameter int BIT_POS = 31
) (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [63:0] n1_i,
  input  wire logic [31:0] r1_i,
  input  wire logic [63:0] n2_i,
  input  wire logic [31:0] r2_i,
  output logic      [63:0] n1_o,
  output logic      [31:0] r1_o,
  output logic      [63:0] n2_o,
  output logic      [31:0] r2_o
);
  // Each root yields two result bits per stage: bit BIT_POS and the bit below it.
  function automatic logic [95:0] step(input logic [63:0] n, input logic [31:0] r,
                                       input int pos);
    logic [63:0] trial;
    trial = ({32'd0, r} << (pos + 1)) + (64'd1 << (2 * pos));
    if (n >= trial) return {n - trial, r | (32'd1 << pos)};
    return {n, r};
  endfunction
  logic [95:0] h1, h2, s1, s2;
  always_comb begin
    h1 = step(n1_i, r1_i, BIT_POS);
    h2 = step(n2_i, r2_i, BIT_POS);
    s1 = step(h1[95:32], h1[31:0], BIT_POS - 1);
    s2 = step(h2[95:32], h2[31:0], BIT_POS - 1);
  end
  always_ff @(posedge clk) begin
    if (en) begin
      n1_o <= s1[95:32]; r1_o <= s1[31:0];
      n2_o <= s2[95:32]; r2_o <= s2[31:0];
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/dia_cordic_stage.sv
// One registered micro-rotation of two vectoring CORDIC chains.
`timescale 1ns / 1ps
`default_nettype none
module dia_cordic_stage
  import dia_pkg::*;
#(
  parameter int SHIFT = 0
) (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic signed [VW-1:0] a1_i, b1_i,
  input  wire logic signed [AW-1:0] g1_i,
  input  wire logic signed [VW-1:0] a2_i, b2_i,
  input  wire logic signed [AW-1:0] g2_i,
  output logic      signed [VW-1:0] a1_o, b1_o,
  output logic      signed [AW-1:0] g1_o,
  output logic      signed [VW-1:0] a2_o, b2_o,
  output logic      signed [AW-1:0] g2_o
);
  localparam logic signed [AW-1:0] ATAN = atan_val(SHIFT);
  always_ff @(posedge clk) begin
    if (en) begin
      if (!b1_i[VW-1]) begin
        a1_o <= a1_i + (b1_i >>> SHIFT); b1_o <= b1_i - (a1_i >>> SHIFT);
        g1_o <= g1_i + ATAN;
      end else begin
        a1_o <= a1_i - (b1_i >>> SHIFT); b1_o <= b1_i + (a1_i >>> SHIFT);
        g1_o <= g1_i - ATAN;
      end
      if (!b2_i[VW-1]) begin
        a2_o <= a2_i + (b2_i >>> SHIFT); b2_o <= b2_i - (a2_i >>> SHIFT);
        g2_o <= g2_i + ATAN;
      end else begin
        a2_o <= a2_i - (b2_i >>> SHIFT); b2_o <= b2_i + (a2_i >>> SHIFT);
        g2_o <= g2_i - ATAN;
      end
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/direction_to_incl_azimuth_core.sv
// Top level of the pipelined direction vector to inclination and azimuth converter.
//
//   Channel  Role     Payload
//   in_      sink     dir_x, dir_y, dir_z
//   out_     source   inclination, azimuth, zero_vector
//   cfg_     sink     register index, write data (always ready)
//
// One transfer enters per cycle unless the output stalls. The pipe is 2 + 16 + 16 + 2
// registers deep at the default CORDIC_STAGES (normalize, squares, 16 root stages,
// the CORDIC stages, one finish stage and the output register).
// The whole pipe advances together; when the output holds a result that is
// not taken, every stage freezes, so nothing is lost or repeated.
// Reset (synchronous, active low) clears the valid bits and sets both
// thresholds to one.
`timescale 1ns / 1ps
`default_nettype none
`include "direction_to_incl_azimuth_core_macros.svh"
module direction_to_incl_azimuth_core
  import dia_pkg::*;
#(
  parameter int COMPONENT_BITS  = COMPONENT_BITS_DEF,
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
  parameter int CORDIC_STAGES   = CORDIC_STAGES_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  dia_if.sink               in_ch,
  dia_if.source             out_ch,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data
);
  localparam int CB = COMPONENT_BITS;
  localparam int NS = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
  localparam int SQ = 16;               // square root: 2 bits each of 16 stages
  localparam int NST = 2 + SQ + NS + 1; // normalize, squares, roots, CORDIC, finish
  localparam int RK = INT_FRAC - ANGLE_FRAC_BITS;

  // Sideband carried beside the arithmetic.
  typedef struct packed {
    logic        zero;
    logic        zneg;
    logic        xpos;
    logic        xneg;
    logic        ypos;
    logic        yneg;
    logic [30:0] ax;
  } side_t;

  cfg_t cfg_r;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{near_zero_angle: CFG_W'(1), near_zero_component: CFG_W'(1)};
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_NEAR_ZERO_ANGLE: cfg_r.near_zero_angle     <= cfg_data;
        REG_NEAR_ZERO_COMP:  cfg_r.near_zero_component <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [NST-1:0] vld_r;
  logic adv;
  assign adv = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= {vld_r[NST-2:0], in_ch.valid};
  end

  // ---- stage 0: magnitudes and normalization to [2^29, 2^30)
  logic signed [CB-1:0] x_in, y_in, z_in;
  assign x_in = in_ch.data[3*CB-1:2*CB];
  assign y_in = in_ch.data[2*CB-1:CB];
  assign z_in = in_ch.data[CB-1:0];
  logic [CB:0] mx, my, mz, mm;
  logic [5:0]  lz;
  logic [30:0] nx, ny, nz;
  always_comb begin
    mx = x_in[CB-1] ? (CB+1)'(-$signed({x_in[CB-1], x_in})) : {1'b0, x_in};
    my = y_in[CB-1] ? (CB+1)'(-$signed({y_in[CB-1], y_in})) : {1'b0, y_in};
    mz = z_in[CB-1] ? (CB+1)'(-$signed({z_in[CB-1], z_in})) : {1'b0, z_in};
    mm = mx | my | mz;  // same leading one as the max
    lz = '0;
    for (int i = 0; i <= CB; i++) if (mm[i]) lz = 6'(i);
    if (lz <= 6'd29) begin
      nx = 31'({{(64-CB-1){1'b0}}, mx} << (29 - lz));
      ny = 31'({{(64-CB-1){1'b0}}, my} << (29 - lz));
      nz = 31'({{(64-CB-1){1'b0}}, mz} << (29 - lz));
    end else begin
      nx = 31'(mx >> (lz - 6'd29));
      ny = 31'(my >> (lz - 6'd29));
      nz = 31'(mz >> (lz - 6'd29));
    end
  end
  side_t side0_r;
  logic [30:0] ny_r, nz_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      side0_r <= '{zero: (mm == '0), zneg: z_in[CB-1], xpos: !x_in[CB-1] && x_in != '0,
                   xneg: x_in[CB-1], ypos: !y_in[CB-1] && y_in != '0,
                   yneg: y_in[CB-1], ax: nx};
      ny_r    <= ny;
      nz_r    <= nz;
    end
  end

  // ---- stage 1: squared lengths of the horizontal part and of the whole vector
  side_t sd_r [SQ+NS+2];
  logic [63:0] n1_r, n2_r;
  logic [31:0] az0_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      sd_r[0] <= side0_r;
      n1_r  <= 64'(side0_r.ax) * 64'(side0_r.ax) + 64'(ny_r) * 64'(ny_r);
      n2_r  <= 64'(side0_r.ax) * 64'(side0_r.ax) + 64'(ny_r) * 64'(ny_r)
               + 64'(nz_r) * 64'(nz_r);
      az0_r <= {1'b0, nz_r};
    end
  end
  // y magnitude travels through the root stages alongside
  logic [30:0] ay_d [SQ+1];
  logic [31:0] az_d [SQ+1];
  always_ff @(posedge clk) if (adv) ay_d[0] <= ny_r;
  assign az_d[0] = az0_r;

  // ---- square roots
  logic [63:0] sn1 [SQ+1], sn2 [SQ+1];
  logic [31:0] sr1 [SQ+1], sr2 [SQ+1];
  assign sn1[0] = n1_r; assign sn2[0] = n2_r;
  assign sr1[0] = '0;   assign sr2[0] = '0;
  for (genvar k = 0; k < SQ; k++) begin : g_sq
    dia_isqrt_stage #(.BIT_POS(31 - 2*k)) u_sq (
      .clk, .en(adv), .n1_i(sn1[k]), .r1_i(sr1[k]), .n2_i(sn2[k]), .r2_i(sr2[k]),
      .n1_o(sn1[k+1]), .r1_o(sr1[k+1]), .n2_o(sn2[k+1]), .r2_o(sr2[k+1]));
    always_ff @(posedge clk) begin
      if (adv) begin
        sd_r[k+1] <= sd_r[k];
        ay_d[k+1] <= ay_d[k];
        az_d[k+1] <= az_d[k];
      end
    end
  end

  // ---- CORDIC: chain 1 inclination (|z|, rho), chain 2 azimuth (|x|, signed y)
  logic signed [VW-1:0] ca1 [NS+1], cb1 [NS+1], ca2 [NS+1], cb2 [NS+1];
  logic signed [AW-1:0] cg1 [NS+1], cg2 [NS+1];
  logic [31:0] len_d [NS+1];
  logic signed [VW-1:0] yb;
  always_comb begin
    yb = VW'(ay_d[SQ]);
    if (sd_r[SQ].yneg ^ sd_r[SQ].xneg) yb = -yb;
  end
  assign ca1[0] = VW'(az_d[SQ]); assign cb1[0] = VW'(sr1[SQ]); assign cg1[0] = '0;
  assign ca2[0] = VW'(sd_r[SQ].ax); assign cb2[0] = yb;      assign cg2[0] = '0;
  assign len_d[0] = sr2[SQ];
  for (genvar k = 0; k < NS; k++) begin : g_cd
    dia_cordic_stage #(.SHIFT(k)) u_c (
      .clk, .en(adv),
      .a1_i(ca1[k]), .b1_i(cb1[k]), .g1_i(cg1[k]),
      .a2_i(ca2[k]), .b2_i(cb2[k]), .g2_i(cg2[k]),
      .a1_o(ca1[k+1]), .b1_o(cb1[k+1]), .g1_o(cg1[k+1]),
      .a2_o(ca2[k+1]), .b2_o(cb2[k+1]), .g2_o(cg2[k+1]));
    always_ff @(posedge clk) begin
      if (adv) begin
        sd_r[SQ+1+k] <= sd_r[SQ+k];
        len_d[k+1]   <= len_d[k];
      end
    end
  end

  // ---- finish stage A: saturate, round, small-x test
  localparam logic signed [AW-1:0] D90 = AW'(64'sd90 <<< INT_FRAC);
  localparam logic signed [AW:0]   D180 = (AW+1)'(64'sd180 <<< INT_FRAC);
  localparam logic signed [AW:0]   HALF = (AW+1)'(64'sd1 <<< (RK - 1));
  localparam int OW = AW + 2;
  logic signed [AW-1:0] p_s, f_s;
  logic signed [AW:0]   iv, fv;
  logic signed [OW-1:0] incl_a, phi_a;
  always_comb begin
    p_s = cg1[NS];
    if (p_s < 0) p_s = '0;
    if (p_s > D90) p_s = D90;
    f_s = cg2[NS];
    if (f_s > D90) f_s = D90;
    if (f_s < -D90) f_s = -D90;
    iv = sd_r[SQ+NS].zneg ? D180 - (AW+1)'(p_s) : (AW+1)'(p_s);
    fv = (AW+1)'(f_s);
    incl_a = OW'((iv + HALF) >>> RK);
    phi_a  = OW'((fv + HALF) >>> RK);
  end
  side_t sdA_r;
  logic signed [OW-1:0] incl_r, phi_r;
  logic smallx_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      sdA_r    <= sd_r[SQ+NS];
      incl_r   <= incl_a;
      phi_r    <= phi_a;
      smallx_r <= (48'(sd_r[SQ+NS].ax) << 15)
                  <= 48'(len_d[NS]) * 48'(cfg_r.near_zero_component);
    end
  end
  assign sd_r[SQ+NS+1] = sdA_r;

  // ---- finish stage B: case selection into the output register
  localparam logic signed [OW-1:0] O90  = OW'(90  << ANGLE_FRAC_BITS);
  localparam logic signed [OW-1:0] O180 = OW'(180 << ANGLE_FRAC_BITS);
  localparam logic signed [OW-1:0] O270 = OW'(270 << ANGLE_FRAC_BITS);
  localparam logic signed [OW-1:0] O360 = OW'(360 << ANGLE_FRAC_BITS);
  logic [INCL_W-1:0] incl_o;
  logic [AZI_W-1:0]  azi_o;
  logic signed [OW-1:0] azs, phm;
  always_comb begin
    phm = phi_r[OW-1] ? -phi_r : phi_r;
    priority if (smallx_r) azs = sdA_r.ypos ? O90 : O270;
    else if (phm <= OW'(cfg_r.near_zero_angle)) azs = sdA_r.xpos ? '0 : O180;
    else if (sdA_r.xpos) azs = phi_r[OW-1] ? phi_r + O360 : phi_r;
    else azs = phi_r + O180;
    incl_o = INCL_W'(incl_r);
    azi_o  = AZI_W'(azs);
    if (sdA_r.zero || incl_r < OW'(cfg_r.near_zero_angle)) begin
      incl_o = '0;
      azi_o  = '0;
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) out_ch.valid <= 1'b0;
    else if (adv) out_ch.valid <= vld_r[NST-1];
    if (adv) out_ch.data <= {incl_o, azi_o, sdA_r.zero};
  end

  `DIA_ASSERT_IMP(a_stall_holds, clk, rst_n, out_ch.valid && !out_ch.ready,
                  !in_ch.ready, "input accepted while output stalled")
  `DIA_ASSERT_NXT(a_out_from_pipe, clk, rst_n, adv && !vld_r[NST-1],
                  !out_ch.valid, "result without a preceding item")
  `DIA_ASSERT_IMP(a_zero_angles, clk, rst_n, out_ch.valid && out_ch.data[0],
                  out_ch.data[INCL_W+AZI_W:1] == '0, "zero vector with nonzero angles")
endmodule
`default_nettype wire
